/* design/vertex_normal_accumulator_macros.svh */
// vertex_normal_accumulator_macros.svh: assertion macros for the vertex normal block
// depends on nothing; every asserting module samples on clock and is quiet in reset
`ifndef VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define VNA_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VNA_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/vna_pkg.sv */
// vna_pkg: sizes, payload structs, item codes and controller/datapath links
// for the vertex normal accumulator; depends on nothing
package vna_pkg;

   // storage and arithmetic sizes
   localparam int MAX_VERTICES = 4096;
   localparam int VIDX_BITS    = $clog2(MAX_VERTICES);
   localparam int INDEX_BITS   = 12;
   localparam int IDXC_BITS    = INDEX_BITS + 1;
   localparam int COORD_BITS   = 16;
   localparam int EDGE_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * EDGE_BITS;
   localparam int FACE_BITS    = PROD_BITS + 1;
   localparam int SUM_BITS     = 48;
   localparam int OUT_BITS     = 48;

   // item codes
   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_TRI  = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   typedef struct packed {
      logic [1:0]                    mode;
      logic [INDEX_BITS-1:0]         vertex_index;
      logic [INDEX_BITS-1:0]         corner_b;
      logic [INDEX_BITS-1:0]         corner_c;
      logic signed [COORD_BITS-1:0]  pos_x;
      logic signed [COORD_BITS-1:0]  pos_y;
      logic signed [COORD_BITS-1:0]  pos_z;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]       read_index;
      logic signed [OUT_BITS-1:0]  normal_x;
      logic signed [OUT_BITS-1:0]  normal_y;
      logic signed [OUT_BITS-1:0]  normal_z;
   } rsp_type;

   typedef enum logic [1:0] {
      CORNER_A,
      CORNER_B,
      CORNER_C
   } corner_type;

   // controller to datapath
   typedef struct packed {
      logic        cap;
      logic        pos_wr;
      logic        pos_rd0;
      logic        pos_rd1;
      corner_type  pos_sel;
      logic        e1_en;
      logic        e2_en;
      logic        mul_en;
      logic [2:0]  mul_sel;
      logic        term_en;
      logic        face_en;
      logic [1:0]  face_sel;
      logic        nrm_rd;
      logic        nrm_wr;
      logic        nrm_clr;
      corner_type  corner;
      logic        rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0]  mode;
      logic        a_ok;
      logic        tri_ok;
      logic        rsp_free;
   } sts_type;

endpackage

/* design/vna_ctrl.sv */
// vna_ctrl: sequencer for load, triangle and read items
// depends on vna_pkg and the assertion macro header
`include "vertex_normal_accumulator_macros.svh"

module vna_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vna_pkg::sts_type  sts,
   output vna_pkg::cmd_type  cmd
);
   import vna_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_POS_AB,
      ST_POS_C,
      ST_EDGE,
      ST_MUL,
      ST_ACC_RD,
      ST_ACC_WR,
      ST_NRM_RD,
      ST_RSP
   } state_type;

   localparam logic [2:0] MUL_LAST = 3'd6;
   localparam logic [2:0] MUL_PROD_LAST = 3'd5;

   state_type   state_ff, state_in;
   logic [2:0]  mul_cnt_ff, mul_cnt_in;
   corner_type  corner_ff, corner_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state
   always_comb begin
      state_in   = state_ff;
      mul_cnt_in = mul_cnt_ff;
      corner_in  = corner_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (sts.mode)
               MODE_TRI:  state_in = sts.tri_ok ? ST_POS_AB : ST_IDLE;
               MODE_READ: state_in = ST_NRM_RD;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_POS_AB: state_in = ST_POS_C;
         ST_POS_C:  state_in = ST_EDGE;
         ST_EDGE: begin
            state_in   = ST_MUL;
            mul_cnt_in = '0;
         end
         ST_MUL: begin
            if (mul_cnt_ff == MUL_LAST) begin
               state_in  = ST_ACC_RD;
               corner_in = CORNER_A;
            end else begin
               mul_cnt_in = mul_cnt_ff + 3'd1;
            end
         end
         ST_ACC_RD: state_in = ST_ACC_WR;
         ST_ACC_WR: begin
            unique case (corner_ff)
               CORNER_A: begin
                  corner_in = CORNER_B;
                  state_in  = ST_ACC_RD;
               end
               CORNER_B: begin
                  corner_in = CORNER_C;
                  state_in  = ST_ACC_RD;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_NRM_RD: state_in = ST_RSP;
         ST_RSP: begin
            if (sts.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mul_cnt_ff <= '0;
         corner_ff  <= CORNER_A;
      end else begin
         state_ff   <= state_in;
         mul_cnt_ff <= mul_cnt_in;
         corner_ff  <= corner_in;
      end
   end

   // command decode
   always_comb begin
      cmd = '0;
      cmd.pos_sel = CORNER_B;
      cmd.corner  = CORNER_A;
      unique case (state_ff)
         ST_IDLE: cmd.cap = req_valid;
         ST_DISPATCH: begin
            if (sts.mode == MODE_LOAD && sts.a_ok) begin
               cmd.pos_wr  = 1'b1;
               cmd.nrm_wr  = 1'b1;
               cmd.nrm_clr = 1'b1;
            end
         end
         ST_POS_AB: begin
            cmd.pos_rd0 = 1'b1;
            cmd.pos_rd1 = 1'b1;
         end
         ST_POS_C: begin
            cmd.pos_rd1 = 1'b1;
            cmd.pos_sel = CORNER_C;
            cmd.e1_en   = 1'b1;
         end
         ST_EDGE: cmd.e2_en = 1'b1;
         ST_MUL: begin
            // products issue in pairs; second of each pair completes a component
            cmd.mul_en   = (mul_cnt_ff <= MUL_PROD_LAST);
            cmd.mul_sel  = mul_cnt_ff;
            cmd.term_en  = mul_cnt_ff[0];
            cmd.face_en  = (mul_cnt_ff != 3'd0) && !mul_cnt_ff[0];
            cmd.face_sel = mul_cnt_ff[2:1] - 2'd1;
         end
         ST_ACC_RD: begin
            cmd.nrm_rd = 1'b1;
            cmd.corner = corner_ff;
         end
         ST_ACC_WR: begin
            cmd.nrm_wr = 1'b1;
            cmd.corner = corner_ff;
         end
         ST_NRM_RD: cmd.nrm_rd = 1'b1;
         ST_RSP: cmd.rsp_load = sts.rsp_free;
         default: cmd.cap = 1'b0;
      endcase
   end

   `VNA_ASSERT_IMP(a_mul_step, state_ff == ST_MUL, mul_cnt_ff <= MUL_LAST, "mul step past end")
   `VNA_ASSERT_NXT(a_accept_dispatch, req_valid && req_ready, state_ff == ST_DISPATCH, "no dispatch after transfer")
   `VNA_ASSERT_NXT(a_rsp_wait, (state_ff == ST_RSP) && !sts.rsp_free, state_ff == ST_RSP, "left rsp wait early")

endmodule

/* design/vna_datapath.sv */
// vna_datapath: position and normal memories, edge and cross product unit,
// saturating accumulate and the result register; depends on vna_pkg and macros
`include "vertex_normal_accumulator_macros.svh"

module vna_datapath (
   input  logic              clock,
   input  logic              reset,
   input  vna_pkg::req_type  req_data,
   input  vna_pkg::cmd_type  cmd,
   output vna_pkg::sts_type  sts,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output vna_pkg::rsp_type  rsp_data
);
   import vna_pkg::*;

   localparam logic [IDXC_BITS-1:0] VERT_LIMIT = IDXC_BITS'(MAX_VERTICES);
   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   function automatic logic idx_ok(input logic [INDEX_BITS-1:0] idx);
      idx_ok = ({1'b0, idx} < VERT_LIMIT);
   endfunction

   // add with clamp at the signed sum limits
   function automatic logic signed [SUM_BITS-1:0] sat_add(
      input logic signed [SUM_BITS-1:0]  acc,
      input logic signed [FACE_BITS-1:0] inc
   );
      logic signed [SUM_BITS:0] s;
      s = (SUM_BITS+1)'(acc) + (SUM_BITS+1)'(inc);
      if (s[SUM_BITS] != s[SUM_BITS-1]) begin
         sat_add = s[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end else begin
         sat_add = s[SUM_BITS-1:0];
      end
   endfunction

   req_type  item_ff;

   logic [3*COORD_BITS-1:0]  pos_mem [MAX_VERTICES];
   logic [3*COORD_BITS-1:0]  pos_rd0_ff, pos_rd1_ff;
   logic [3*SUM_BITS-1:0]    nrm_mem [MAX_VERTICES];
   logic [3*SUM_BITS-1:0]    nrm_rd_ff;
   logic [3*SUM_BITS-1:0]    nrm_wdata;

   logic signed [EDGE_BITS-1:0]  e1_ff [3];
   logic signed [EDGE_BITS-1:0]  e2_ff [3];
   logic signed [EDGE_BITS-1:0]  edge_in [3];
   logic signed [EDGE_BITS-1:0]  mul_a, mul_b;
   logic signed [PROD_BITS-1:0]  mul_p;
   logic signed [PROD_BITS-1:0]  prod_ff, term_ff;
   logic signed [FACE_BITS-1:0]  face_ff [3];

   logic [VIDX_BITS-1:0]  addr_a, addr_b, addr_c, pos_addr1, nrm_addr;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   assign addr_a = item_ff.vertex_index[VIDX_BITS-1:0];
   assign addr_b = item_ff.corner_b[VIDX_BITS-1:0];
   assign addr_c = item_ff.corner_c[VIDX_BITS-1:0];

   // status back to the sequencer
   assign sts.mode     = item_ff.mode;
   assign sts.a_ok     = idx_ok(item_ff.vertex_index);
   assign sts.tri_ok   = idx_ok(item_ff.vertex_index) && idx_ok(item_ff.corner_b) &&
                         idx_ok(item_ff.corner_c);
   assign sts.rsp_free = !rsp_valid_ff || rsp_ready;

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         item_ff <= req_data;
      end
   end

   // position memory, one write and two read ports
   assign pos_addr1 = (cmd.pos_sel == CORNER_C) ? addr_c : addr_b;

   always_ff @(posedge clock) begin
      if (cmd.pos_wr) begin
         pos_mem[addr_a] <= {item_ff.pos_z, item_ff.pos_y, item_ff.pos_x};
      end
      if (cmd.pos_rd0) begin
         pos_rd0_ff <= pos_mem[addr_a];
      end
      if (cmd.pos_rd1) begin
         pos_rd1_ff <= pos_mem[pos_addr1];
      end
   end

   // edge vectors: port 1 corner minus corner a
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         edge_in[k] = EDGE_BITS'($signed(pos_rd1_ff[k*COORD_BITS +: COORD_BITS])) -
                      EDGE_BITS'($signed(pos_rd0_ff[k*COORD_BITS +: COORD_BITS]));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.e1_en) begin
         e1_ff <= edge_in;
      end
      if (cmd.e2_en) begin
         e2_ff <= edge_in;
      end
   end

   // shared multiplier operand select, two products per cross component
   always_comb begin
      unique case (cmd.mul_sel)
         3'd0: begin mul_a = e1_ff[1]; mul_b = e2_ff[2]; end
         3'd1: begin mul_a = e1_ff[2]; mul_b = e2_ff[1]; end
         3'd2: begin mul_a = e1_ff[2]; mul_b = e2_ff[0]; end
         3'd3: begin mul_a = e1_ff[0]; mul_b = e2_ff[2]; end
         3'd4: begin mul_a = e1_ff[0]; mul_b = e2_ff[1]; end
         3'd5: begin mul_a = e1_ff[1]; mul_b = e2_ff[0]; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      if (cmd.term_en) begin
         term_ff <= prod_ff;
      end
      if (cmd.face_en) begin
         face_ff[cmd.face_sel] <= FACE_BITS'(term_ff) - FACE_BITS'(prod_ff);
      end
   end

   // normal memory, read-modify-write one corner at a time
   always_comb begin
      unique case (cmd.corner)
         CORNER_B: nrm_addr = addr_b;
         CORNER_C: nrm_addr = addr_c;
         default:  nrm_addr = addr_a;
      endcase
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         nrm_wdata[k*SUM_BITS +: SUM_BITS] = cmd.nrm_clr ? '0 :
            sat_add($signed(nrm_rd_ff[k*SUM_BITS +: SUM_BITS]), face_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.nrm_wr) begin
         nrm_mem[nrm_addr] <= nrm_wdata;
      end
      if (cmd.nrm_rd) begin
         nrm_rd_ff <= nrm_mem[nrm_addr];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff.read_index <= item_ff.vertex_index;
         if (sts.a_ok) begin
            rsp_data_ff.normal_x <= OUT_BITS'(nrm_rd_ff[0*SUM_BITS +: SUM_BITS]);
            rsp_data_ff.normal_y <= OUT_BITS'(nrm_rd_ff[1*SUM_BITS +: SUM_BITS]);
            rsp_data_ff.normal_z <= OUT_BITS'(nrm_rd_ff[2*SUM_BITS +: SUM_BITS]);
         end else begin
            rsp_data_ff.normal_x <= '0;
            rsp_data_ff.normal_y <= '0;
            rsp_data_ff.normal_z <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `VNA_ASSERT_IMP(a_rsp_load_free, cmd.rsp_load, !rsp_valid_ff || rsp_ready, "result overwritten")
   `VNA_ASSERT_IMP(a_nrm_one_port, cmd.nrm_wr, !cmd.nrm_rd, "normal read and write together")
   `VNA_ASSERT_NXT(a_rsp_index, cmd.rsp_load, rsp_valid_ff && (rsp_data_ff.read_index == $past(item_ff.vertex_index)), "result index mismatch")

endmodule

/* design/vertex_normal_accumulator.sv */
// vertex_normal_accumulator: top level, sequencer plus datapath
// depends on vna_pkg, vna_ctrl and vna_datapath
//
//   channel  ports                          payload
//   req      req_valid, req_ready           req_data (vna_pkg::req_type)
//   rsp      rsp_valid, rsp_ready           rsp_data (vna_pkg::rsp_type)
//
// one item at a time; a read also waits out any result stall, and a triangle
// makes three position reads over two memory ports, six products on
// one shared multiplier and three read-modify-writes on the single normal port
// reset is synchronous and clears control only; the memories hold nothing
// defined until loaded, and no clearing pass runs
// a finished result waits in its own register, so the next item is taken meanwhile

module vertex_normal_accumulator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vna_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vna_pkg::rsp_type  rsp_data
);
   import vna_pkg::*;

   cmd_type  cmd;
   sts_type  sts;

   // sequencer
   vna_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // memories and arithmetic
   vna_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
